@@ hw/rtl/dpm_pkg.sv @@
// Shared types, constants and the log table for the Magnus dew-point core.
// No dependencies; imported by dew_point_magnus_core and by its testbench.
`default_nettype none

package dpm_pkg;

    // Outcome of a saturating divide: plain quotient or a forced value.
    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_MAX,
        SAT_MIN,
        SAT_ZERO
    } sat_t;

    // Configuration register indexes.
    localparam logic CFG_COEF_A = 1'b0;
    localparam logic CFG_COEF_B = 1'b1;

    localparam int COEF_A_W = 24;
    localparam int COEF_B_W = 25;
    localparam logic [COEF_A_W-1:0] COEF_A_RST = 24'd1131872;
    localparam logic [COEF_B_W-1:0] COEF_B_RST = 25'd15577907;

    localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
    localparam logic signed [15:0] Q8_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] Q8_MIN  = 16'sh8000;

    localparam int LN_W = 20;
    localparam int LN_ENTRIES = 101;
    localparam logic [6:0] HUM_FULL = 7'd100;

    // ln(h/100) in Q16.16, rounded to nearest; entry 0 is unused (zero).
    localparam logic signed [LN_W-1:0] LN_TAB [0:LN_ENTRIES-1] = '{
        20'sd0,
        -20'sd301804, -20'sd256378, -20'sd229806, -20'sd210952, -20'sd196328,
        -20'sd184380, -20'sd174277, -20'sd165526, -20'sd157807, -20'sd150902,
        -20'sd144656, -20'sd138954, -20'sd133708, -20'sd128851, -20'sd124330,
        -20'sd120100, -20'sd116127, -20'sd112381, -20'sd108838, -20'sd105476,
        -20'sd102279, -20'sd99230,  -20'sd96317,  -20'sd93527,  -20'sd90852,
        -20'sd88282,  -20'sd85808,  -20'sd83425,  -20'sd81125,  -20'sd78904,
        -20'sd76755,  -20'sd74674,  -20'sd72657,  -20'sd70701,  -20'sd68801,
        -20'sd66955,  -20'sd65159,  -20'sd63412,  -20'sd61709,  -20'sd60050,
        -20'sd58432,  -20'sd56853,  -20'sd55310,  -20'sd53804,  -20'sd52331,
        -20'sd50891,  -20'sd49481,  -20'sd48101,  -20'sd46750,  -20'sd45426,
        -20'sd44128,  -20'sd42856,  -20'sd41607,  -20'sd40382,  -20'sd39180,
        -20'sd37999,  -20'sd36839,  -20'sd35699,  -20'sd34579,  -20'sd33477,
        -20'sd32394,  -20'sd31329,  -20'sd30280,  -20'sd29248,  -20'sd28232,
        -20'sd27231,  -20'sd26246,  -20'sd25275,  -20'sd24318,  -20'sd23375,
        -20'sd22445,  -20'sd21529,  -20'sd20625,  -20'sd19733,  -20'sd18854,
        -20'sd17985,  -20'sd17129,  -20'sd16283,  -20'sd15448,  -20'sd14624,
        -20'sd13810,  -20'sd13006,  -20'sd12211,  -20'sd11426,  -20'sd10651,
        -20'sd9884,   -20'sd9127,   -20'sd8378,   -20'sd7637,   -20'sd6905,
        -20'sd6181,   -20'sd5464,   -20'sd4756,   -20'sd4055,   -20'sd3362,
        -20'sd2675,   -20'sd1996,   -20'sd1324,   -20'sd659,    20'sd0
    };

    // Pick the forced result of a divide, if any.
    function automatic sat_t sat_kind(input logic den_zero, input logic num_zero,
                                      input logic num_neg, input logic too_big,
                                      input logic quo_neg);
        sat_t k;
        k = SAT_NONE;
        if (den_zero) begin
            if (num_zero) begin
                k = SAT_ZERO;
            end else if (num_neg) begin
                k = SAT_MIN;
            end else begin
                k = SAT_MAX;
            end
        end else if (too_big) begin
            k = quo_neg ? SAT_MIN : SAT_MAX;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dew_point_magnus_core.sv @@
// Magnus dew-point core: gamma = a*T/(b+T) + ln(RH/100), dew = b*gamma/(a-gamma).
// One word per cycle sustained while the result word is not stalled.
// 55 register stages: stage 1 loads at the accept, then two bit-per-stage dividers
// (32 and 17 stages, each behind an input register), gamma, product and output.
// A stalled result word freezes the whole pipeline; nothing is dropped.
// Synchronous active-low reset clears all valid bits and restores a and b defaults.
`default_nettype none

module dew_point_magnus_core
    import dpm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [7:0]   s_temperature_c,
    input  wire logic [6:0]          s_humidity_pct,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [15:0]       m_dew_point_q8,
    output logic                     m_invalid,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [COEF_B_W-1:0] cfg_data
);

    logic                adv;
    logic [COEF_A_W-1:0] coef_a_reg;
    logic [COEF_B_W-1:0] coef_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg <= COEF_A_RST;
            coef_b_reg <= COEF_B_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_COEF_A: coef_a_reg <= cfg_data[COEF_A_W-1:0];
                CFG_COEF_B: coef_b_reg <= cfg_data;
                default:    coef_b_reg <= coef_b_reg;
            endcase
        end
    end

    // ---------------- stage 1: a*T, b+T, log lookup ----------------
    logic                   s1_vld_reg;
    logic signed [32:0]     s1_at_reg, s1_at_next;
    logic signed [26:0]     s1_den_reg, s1_den_next;
    logic signed [LN_W-1:0] s1_ln_reg, s1_ln_next;
    logic                   s1_inv_reg;
    logic [6:0]             hum_clip;

    always_comb begin
        hum_clip    = (s_humidity_pct > HUM_FULL) ? HUM_FULL : s_humidity_pct;
        s1_ln_next  = LN_TAB[hum_clip];
        s1_at_next  = $signed({1'b0, coef_a_reg}) * s_temperature_c;
        s1_den_next = $signed({2'b00, coef_b_reg})
                    + $signed({{3{s_temperature_c[7]}}, s_temperature_c, 16'h0000});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_at_reg  <= s1_at_next;
            s1_den_reg <= s1_den_next;
            s1_ln_reg  <= s1_ln_next;
            s1_inv_reg <= (s_humidity_pct == 7'd0);
        end
    end

    // ---------------- first divide: a*T*2^16 / (b + T*2^16) ----------------
    logic        at_neg, d1_neg, d1_zero, d1_big;
    logic [30:0] at_mag;
    logic [25:0] d1_mag;
    logic [14:0] d1_hi;
    logic [31:0] d1_lo;
    sat_t        d1_kind;
    logic [LN_W+3:0] d1_side;

    always_comb begin
        at_neg  = s1_at_reg[32];
        at_mag  = at_neg ? 31'(-s1_at_reg) : s1_at_reg[30:0];
        d1_neg  = s1_den_reg[26];
        d1_mag  = d1_neg ? 26'(-s1_den_reg) : s1_den_reg[25:0];
        d1_hi   = at_mag[30:16];
        d1_lo   = {at_mag[15:0], 16'h0000};
        d1_zero = (d1_mag == 26'd0);
        d1_big  = {11'd0, d1_hi} >= d1_mag;
        d1_kind = sat_kind(d1_zero, at_mag == 31'd0, at_neg, d1_big, at_neg ^ d1_neg);
        d1_side = {d1_kind, at_neg ^ d1_neg, s1_ln_reg, s1_inv_reg};
    end

    logic            q1_vld;
    logic [31:0]     q1;
    logic [LN_W+3:0] q1_side;

    dpm_div_pipe #(
        .QW(32),
        .DW(26),
        .HW(15),
        .SW(LN_W + 4)
    ) u_div_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s1_vld_reg),
        .in_num_hi (d1_hi),
        .in_num_lo (d1_lo),
        .in_den    (d1_mag),
        .in_side   (d1_side),
        .out_valid (q1_vld),
        .out_quo   (q1),
        .out_side  (q1_side)
    );

    // ---------------- gamma = clamp(ratio + ln) ----------------
    sat_t                   q1_kind;
    logic                   q1_neg, q1_inv;
    logic signed [LN_W-1:0] q1_ln;
    logic signed [31:0]     ratio;
    logic signed [32:0]     gsum;
    logic signed [31:0]     g_gamma_reg, g_gamma_next;
    logic                   g_vld_reg, g_inv_reg;

    always_comb begin
        q1_kind = sat_t'(q1_side[LN_W+3:LN_W+2]);
        q1_neg  = q1_side[LN_W+1];
        q1_ln   = q1_side[LN_W:1];
        q1_inv  = q1_side[0];
        case (q1_kind)
            SAT_MAX:  ratio = Q16_MAX;
            SAT_MIN:  ratio = Q16_MIN;
            SAT_ZERO: ratio = 32'sd0;
            SAT_NONE: begin
                if (q1_neg) begin
                    ratio = (q1 > 32'h8000_0000) ? Q16_MIN : $signed(-q1);
                end else begin
                    ratio = q1[31] ? Q16_MAX : $signed(q1);
                end
            end
            default:  ratio = 32'sd0;
        endcase
        gsum = {ratio[31], ratio} + 33'(q1_ln);
        if (gsum[32] != gsum[31]) begin
            g_gamma_next = gsum[32] ? Q16_MIN : Q16_MAX;
        end else begin
            g_gamma_next = gsum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
        end else if (adv) begin
            g_vld_reg <= q1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_gamma_reg <= g_gamma_next;
            g_inv_reg   <= q1_inv;
        end
    end

    // ---------------- b*gamma and a-gamma ----------------
    logic               p_vld_reg, p_inv_reg;
    logic signed [57:0] p_prod_reg, p_prod_next;
    logic signed [33:0] p_dd_reg, p_dd_next;

    always_comb begin
        p_prod_next = $signed({1'b0, coef_b_reg}) * g_gamma_reg;
        p_dd_next   = $signed({10'd0, coef_a_reg}) - $signed({{2{g_gamma_reg[31]}}, g_gamma_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (adv) begin
            p_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_prod_reg <= p_prod_next;
            p_dd_reg   <= p_dd_next;
            p_inv_reg  <= g_inv_reg;
        end
    end

    // ---------------- second divide: b*gamma / ((a-gamma)*256) ----------------
    logic        n2_neg, d2_neg, d2_zero, d2_big;
    logic [55:0] n2_mag;
    logic [31:0] dd_mag;
    logic [39:0] d2_mag;
    logic [38:0] d2_hi;
    logic [16:0] d2_lo;
    sat_t        d2_kind;
    logic [3:0]  d2_side;

    always_comb begin
        n2_neg  = p_prod_reg[57];
        n2_mag  = n2_neg ? 56'(-p_prod_reg) : p_prod_reg[55:0];
        d2_neg  = p_dd_reg[33];
        dd_mag  = d2_neg ? 32'(-p_dd_reg) : p_dd_reg[31:0];
        d2_mag  = {dd_mag, 8'h00};
        d2_hi   = n2_mag[55:17];
        d2_lo   = n2_mag[16:0];
        d2_zero = (dd_mag == 32'd0);
        d2_big  = {1'b0, d2_hi} >= d2_mag;
        d2_kind = sat_kind(d2_zero, n2_mag == 56'd0, n2_neg, d2_big, n2_neg ^ d2_neg);
        d2_side = {d2_kind, n2_neg ^ d2_neg, p_inv_reg};
    end

    logic        q2_vld;
    logic [16:0] q2;
    logic [3:0]  q2_side;

    dpm_div_pipe #(
        .QW(17),
        .DW(40),
        .HW(39),
        .SW(4)
    ) u_div_dew (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (p_vld_reg),
        .in_num_hi (d2_hi),
        .in_num_lo (d2_lo),
        .in_den    (d2_mag),
        .in_side   (d2_side),
        .out_valid (q2_vld),
        .out_quo   (q2),
        .out_side  (q2_side)
    );

    // ---------------- output register ----------------
    sat_t               q2_kind;
    logic               q2_neg;
    logic signed [15:0] dew_next;
    logic               m_vld_reg, m_inv_reg;
    logic signed [15:0] m_dew_reg;

    always_comb begin
        q2_kind = sat_t'(q2_side[3:2]);
        q2_neg  = q2_side[1];
        case (q2_kind)
            SAT_MAX:  dew_next = Q8_MAX;
            SAT_MIN:  dew_next = Q8_MIN;
            SAT_ZERO: dew_next = 16'sd0;
            SAT_NONE: begin
                if (q2_neg) begin
                    dew_next = (q2 > 17'd32768) ? Q8_MIN : $signed(16'(-q2));
                end else begin
                    dew_next = (q2 > 17'd32767) ? Q8_MAX : $signed(q2[15:0]);
                end
            end
            default:  dew_next = 16'sd0;
        endcase
        // zero humidity: drop the computed value
        if (q2_side[0]) begin
            dew_next = 16'sd0;
        end
    end

    assign adv = !m_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= q2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_dew_reg <= dew_next;
            m_inv_reg <= q2_side[0];
        end
    end

    assign s_ready        = adv;
    assign m_valid        = m_vld_reg;
    assign m_dew_point_q8 = m_dew_reg;
    assign m_invalid      = m_inv_reg;

`ifndef NO_ASSERTIONS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_invalid |-> m_dew_point_q8 == 16'sd0)
        else $error("invalid word carries nonzero dew point");

    a_div1_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg && d1_kind == SAT_NONE |-> {11'd0, d1_hi} < d1_mag)
        else $error("first divider fed a quotient that overflows");

    a_div2_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p_vld_reg && d2_kind == SAT_NONE |-> {1'b0, d2_hi} < d2_mag)
        else $error("second divider fed a quotient that overflows");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !q2_vld && !q1_vld)
        else $error("valid bits survive reset");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/dpm_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; used twice by dew_point_magnus_core.
`default_nettype none

module dpm_div_pipe #(
    parameter int QW = 32,
    parameter int DW = 26,
    parameter int HW = 15,
    parameter int SW = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire logic [HW-1:0] in_num_hi,
    input  wire logic [QW-1:0] in_num_lo,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QW-1:0]      out_quo,
    output logic [SW-1:0]      out_side
);

    // Caller guarantees in_num_hi < in_den, so the quotient fits in QW bits.
    logic          vld_reg  [0:QW];
    logic [QW-1:0] wrk_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];
    logic [DW-1:0] rem_reg  [0:QW-1];
    logic [DW-1:0] den_reg  [0:QW-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= DW'(in_num_hi);
            wrk_reg[0]  <= in_num_lo;
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar s = 1; s <= QW; s++) begin : g_step
        logic [DW:0]   trial;
        logic          take;
        logic [QW-1:0] wrk_next;

        always_comb begin
            trial    = {rem_reg[s-1], wrk_reg[s-1][QW-1]};
            take     = trial >= {1'b0, den_reg[s-1]};
            // shift the next dividend bit out, the quotient bit in
            wrk_next = {wrk_reg[s-1][QW-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                wrk_reg[s]  <= wrk_next;
                side_reg[s] <= side_reg[s-1];
            end
        end

        if (s < QW) begin : g_carry
            logic [DW-1:0] rem_next;

            always_comb begin
                rem_next = take ? DW'(trial - {1'b0, den_reg[s-1]}) : trial[DW-1:0];
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[s] <= rem_next;
                    den_reg[s] <= den_reg[s-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quo   = wrk_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

`default_nettype wire

@@ tb/sv/tb_dew_point_magnus_core.sv @@
// Self-checking testbench for dew_point_magnus_core: directed and random readings
// checked against an in-bench Magnus predictor over several coefficient settings.
// Depends on dpm_pkg and the core RTL.
module tb_dew_point_magnus_core import dpm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [7:0] temp;
        logic [6:0]        hum;
    } reading_t;

    typedef struct {
        logic signed [15:0] dew;
        logic               inv;
    } dew_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [7:0]   s_temperature_c = '0;
    logic [6:0]          s_humidity_pct = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [15:0]  m_dew_point_q8;
    logic                m_invalid;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_COEF_A;
    logic [COEF_B_W-1:0] cfg_data = '0;

    reading_t readings_q[$];
    dew_res_t dew_expect_q[$];
    longint   ln_q16 [0:100];
    longint   coef_a = COEF_A_RST;
    longint   coef_b = COEF_B_RST;
    bit       idle_on = 1'b1;
    bit       live = 1'b0;
    int       errors = 0;

    dew_point_magnus_core dut (.*);

    always #10 aclk = ~aclk;

    // atanh(num/den) in Q32 by odd power series
    function automatic longint unsigned atanh32(longint unsigned num, longint unsigned den);
        longint unsigned z, zz, term, sum;
        z = (num << 32) / den;
        zz = (z * z) >> 32;
        term = z;
        sum = z;
        for (int i = 1; i < 24; i++) begin
            term = (term * zz) >> 32;
            sum += term / (2 * i + 1);
        end
        return sum;
    endfunction

    function automatic longint unsigned ln32(longint unsigned n);
        longint unsigned p, k;
        p = 1;
        k = 0;
        while (p * 2 <= n) begin
            p *= 2;
            k++;
        end
        return k * 2 * atanh32(1, 3) + 2 * atanh32(n - p, n + p);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // truncating divide; zero divisor forces the limit with the numerator's sign
    function automatic longint sat_div(longint n, longint d, longint lo, longint hi);
        if (d == 0) return n > 0 ? hi : (n < 0 ? lo : 0);
        return clamp(n / d, lo, hi);
    endfunction

    function automatic dew_res_t magnus_dew(logic signed [7:0] temp, logic [6:0] hum);
        dew_res_t r;
        longint   t, ratio, gam;
        int       h;
        t = temp;
        h = (hum > 100) ? 100 : hum;
        if (hum == 0) begin
            r.dew = '0;
            r.inv = 1'b1;
            return r;
        end
        ratio = sat_div(coef_a * t * 65536, coef_b + t * 65536, -64'sd2147483648, 2147483647);
        gam = clamp(ratio + ln_q16[h], -64'sd2147483648, 2147483647);
        r.dew = 16'(sat_div(coef_b * gam, (coef_a - gam) * 256, -32768, 32767));
        r.inv = 1'b0;
        return r;
    endfunction

    // input driver: predict on accept, then load the next word or idle
    always @(posedge aclk) begin
        reading_t rd;
        if (s_valid && s_ready) dew_expect_q.push_back(magnus_dew(s_temperature_c, s_humidity_pct));
        if (!s_valid || s_ready) begin
            if (live && readings_q.size() > 0 && !(idle_on && $urandom_range(99) < 15)) begin
                rd = readings_q.pop_front();
                s_valid <= 1'b1;
                s_temperature_c <= rd.temp;
                s_humidity_pct <= rd.hum;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        dew_res_t want;
        if (m_valid && m_ready) begin
            if (dew_expect_q.size() == 0) begin
                $display("%t: unexpected word dew=%0d inv=%0b", $time, m_dew_point_q8, m_invalid);
                errors++;
            end else begin
                want = dew_expect_q.pop_front();
                if (want.dew !== m_dew_point_q8) begin
                    $display("%t: dew_point_q8 expected %0d actual %0d", $time, want.dew,
                             m_dew_point_q8);
                    errors++;
                end
                if (want.inv !== m_invalid) begin
                    $display("%t: invalid expected %0b actual %0b", $time, want.inv, m_invalid);
                    errors++;
                end
            end
        end
        m_ready <= live && !(idle_on && $urandom_range(99) < 15);
    end

    task automatic cfg_write(logic idx, longint val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= COEF_B_W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_COEF_A) coef_a = val & 64'hFFFFFF;
        else coef_b = val & 64'h1FFFFFF;
    endtask

    task automatic add(int temp, int hum);
        reading_t rd;
        rd.temp = 8'(temp);
        rd.hum = 7'(hum);
        readings_q.push_back(rd);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) add($urandom_range(120) - 40, $urandom_range(100, 1));
            else add($urandom_range(255), $urandom_range(127));
        end
    endtask

    // hold until every word is back; sample after the edge's updates settle
    task automatic drain();
        do begin
            @(posedge aclk);
            #1;
        end while (readings_q.size() > 0 || dew_expect_q.size() > 0 || s_valid);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        longint unsigned l100;
        l100 = ln32(100);
        ln_q16[0] = 0;
        for (int h = 1; h <= 100; h++) ln_q16[h] = -longint'((l100 - ln32(h) + 32768) >> 16);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        live = 1'b1;

        // extremes, zero humidity, humidity above full scale
        add(-40, 1); add(80, 100); add(-128, 50); add(127, 50); add(0, 0);
        add(25, 0); add(25, 101); add(25, 127); add(-1, 1); add(0, 100);
        add(20, 50); add(-20, 99); add(85, 2); add(-85, 3); add(-100, 64);
        drain();
        add_random(400);
        drain();

        cfg_write(CFG_COEF_A, 24'hFFFFFF);
        cfg_write(CFG_COEF_B, 25'h1FFFFFF);
        add(-128, 1); add(127, 127); add(0, 0); add(-1, 100);
        add_random(150);
        drain();

        // zero coefficients; T = 0 at full humidity drives both divisors to zero
        cfg_write(CFG_COEF_A, 0);
        cfg_write(CFG_COEF_B, 0);
        add(0, 100); add(0, 50); add(10, 100); add(-10, 20); add(0, 0);
        add_random(100);
        drain();

        // b = 40.0 so that T = -40 empties the first divisor
        cfg_write(CFG_COEF_A, $urandom_range(24'hFFFFFF));
        cfg_write(CFG_COEF_B, 40 * 65536);
        add(-40, 100); add(-40, 1); add(-40, 60);
        for (int i = 0; i < 40; i++) add(-40, $urandom_range(127));
        add_random(110);
        drain();

        cfg_write(CFG_COEF_A, $urandom_range(24'hFFFFFF));
        cfg_write(CFG_COEF_B, $urandom_range(25'h1FFFFFF));
        idle_on = 1'b0;
        add_random(200);
        drain();
        idle_on = 1'b1;

        cfg_write(CFG_COEF_A, COEF_A_RST);
        cfg_write(CFG_COEF_B, COEF_B_RST);
        add_random(200);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
